/* sv/stepper_full_step_sequencer_core_defines.svh */
// ---------------------------------------------------------------------------
// Stepper full-step sequencer: assertion macros
// Shared concurrent assertion forms used by the sequencer modules.
// ---------------------------------------------------------------------------
`ifndef STEPPER_FULL_STEP_SEQUENCER_CORE_DEFINES_SVH
`define STEPPER_FULL_STEP_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define SFSS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfss assertion failed");

// next-cycle implication
`define SFSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfss assertion failed");

`endif

/* sv/sfss_pkg.sv */
// ---------------------------------------------------------------------------
// sfss_pkg
// Types, codes and the coil pattern table of the full-step sequencer.
// ---------------------------------------------------------------------------
package sfss_pkg;

   localparam int TimeW  = 24;
   localparam int StepsW = 15;
   localparam int CountW = 16;
   localparam int CsrIdxW = 2;

   localparam logic [TimeW-1:0] PeriodReset = 24'd1000;
   localparam logic [TimeW-1:0] PulseReset  = 24'd0;

   // register indexes
   localparam logic [CsrIdxW-1:0] REG_STEP_PERIOD = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_PULSE_ON    = 2'd1;

   // item opcodes
   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // step stage codes
   localparam logic [1:0] STAGE_IDLE = 2'd0;
   localparam logic [1:0] STAGE_ON   = 2'd1;
   localparam logic [1:0] STAGE_OFF  = 2'd2;

   typedef struct packed {
      logic              op;
      logic signed [CountW-1:0] step_count;
   } req_type;

   typedef struct packed {
      logic [3:0] coils;
      logic       busy_res;
   } rsp_type;

   typedef struct packed {
      logic [TimeW-1:0] step_period_us;
      logic [TimeW-1:0] pulse_on_us;
   } cfg_type;

   function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
      logic [3:0] pat;
      case (phase)
         2'd0:    pat = 4'hA;
         2'd1:    pat = 4'h6;
         2'd2:    pat = 4'h5;
         default: pat = 4'h9;
      endcase
      return pat;
   endfunction

endpackage

/* sv/sfss_engine.sv */
// ---------------------------------------------------------------------------
// sfss_engine
// Step state and next-state logic; each accepted beat updates the registered state.
// ---------------------------------------------------------------------------
`include "stepper_full_step_sequencer_core_defines.svh"

module sfss_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  sfss_pkg::req_type item,
   input  sfss_pkg::cfg_type cfg,
   output sfss_pkg::rsp_type result
);

   logic [sfss_pkg::StepsW-1:0] steps_ff, steps_in;
   logic [1:0]                  phase_ff, phase_in;
   logic                        fwd_ff, fwd_in;
   logic [sfss_pkg::TimeW-1:0]  tc_ff, tc_in;
   logic [1:0]                  stage_ff, stage_in;
   logic [3:0]                  coil_ff, coil_in;

   logic [sfss_pkg::TimeW-1:0]  on_len, off_len, tc_inc;
   logic                        busy;
   logic [sfss_pkg::CountW-1:0] raw, neg_raw;
   logic [sfss_pkg::StepsW-1:0] mag;
   logic                        do_begin;
   logic [sfss_pkg::StepsW-1:0] b_steps;
   logic [1:0]                  b_phase;

   assign on_len  = (cfg.pulse_on_us != '0) ? cfg.pulse_on_us : cfg.step_period_us;
   assign off_len = (cfg.pulse_on_us == '0 || cfg.pulse_on_us >= cfg.step_period_us)
                    ? '0 : cfg.step_period_us - cfg.pulse_on_us;
   assign tc_inc  = tc_ff + 1'b1;
   assign busy    = (stage_ff == sfss_pkg::STAGE_ON) || (stage_ff == sfss_pkg::STAGE_OFF);

   assign raw     = item.step_count;
   assign neg_raw = -raw;
   assign mag     = raw[15] ? (neg_raw[15] ? 15'h7FFF : neg_raw[14:0]) : raw[14:0];

   always_comb begin
      steps_in = steps_ff;
      phase_in = phase_ff;
      fwd_in   = fwd_ff;
      tc_in    = tc_ff;
      stage_in = stage_ff;
      coil_in  = coil_ff;
      do_begin = 1'b0;
      b_steps  = steps_ff;
      b_phase  = phase_ff;

      if (item.op == sfss_pkg::OP_MOVE) begin
         if (!busy && raw != '0) begin
            fwd_in   = ~raw[15];
            b_steps  = mag;
            b_phase  = raw[15] ? mag[1:0] : 2'd0;
            do_begin = 1'b1;
         end
      end else if (stage_ff == sfss_pkg::STAGE_ON) begin
         tc_in = tc_inc;
         if (tc_inc >= on_len) begin
            if (off_len != '0) begin
               coil_in  = 4'h0;
               stage_in = sfss_pkg::STAGE_OFF;
               tc_in    = '0;
            end else begin
               do_begin = 1'b1;
            end
         end
      end else if (stage_ff == sfss_pkg::STAGE_OFF) begin
         tc_in = tc_inc;
         if (tc_inc >= off_len) begin
            do_begin = 1'b1;
         end
      end else begin
         stage_in = sfss_pkg::STAGE_IDLE;
         coil_in  = 4'h0;
      end

      if (do_begin) begin
         tc_in = '0;
         if (b_steps == '0) begin
            coil_in  = 4'h0;
            stage_in = sfss_pkg::STAGE_IDLE;
         end else begin
            steps_in = b_steps - 1'b1;
            phase_in = fwd_in ? b_phase + 2'd1 : b_phase - 2'd1;
            coil_in  = sfss_pkg::coil_pattern(phase_in);
            stage_in = sfss_pkg::STAGE_ON;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         phase_ff <= 2'd0;
         fwd_ff   <= 1'b1;
         tc_ff    <= '0;
         stage_ff <= sfss_pkg::STAGE_IDLE;
         coil_ff  <= 4'h0;
      end else if (take) begin
         steps_ff <= steps_in;
         phase_ff <= phase_in;
         fwd_ff   <= fwd_in;
         tc_ff    <= tc_in;
         stage_ff <= stage_in;
         coil_ff  <= coil_in;
      end
   end

   assign result.coils    = coil_in;
   assign result.busy_res = (stage_in == sfss_pkg::STAGE_ON) ||
                            (stage_in == sfss_pkg::STAGE_OFF);

   `SFSS_ASSERT_NOW(a_off_released, clock, reset,
      stage_ff == sfss_pkg::STAGE_OFF, coil_ff == 4'h0)
   `SFSS_ASSERT_NOW(a_on_two_coils, clock, reset,
      stage_ff == sfss_pkg::STAGE_ON, $countones(coil_ff) == 2)
   `SFSS_ASSERT_NEXT(a_hold_when_idle, clock, reset,
      !take, $stable(stage_ff) && $stable(tc_ff) && $stable(steps_ff))

endmodule

/* sv/stepper_full_step_sequencer_core.sv */
// ---------------------------------------------------------------------------
// stepper_full_step_sequencer_core
// Full-step coil sequencer for a 4-wire stepper, driven by move and tick beats.
//
//   channel  dir  handshake          payload
//   req      in   req_valid/ready    sfss_pkg::req_type (op, step_count)
//   rsp      out  rsp_valid/ready    sfss_pkg::rsp_type (coils, busy_res)
//   csr      in   csr_we             csr_index, csr_wdata (24 bit)
//
// One beat per cycle unless req is stalled; each beat's result is registered
// in the output register on acceptance. The output register stalls req only
// while a result is held and rsp_ready is low. Synchronous active-high reset;
// no clearing pass.
// ---------------------------------------------------------------------------
`include "stepper_full_step_sequencer_core_defines.svh"

module stepper_full_step_sequencer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  sfss_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output sfss_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [sfss_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [sfss_pkg::TimeW-1:0]          csr_wdata
);

   sfss_pkg::cfg_type cfg_ff;
   sfss_pkg::rsp_type result;
   sfss_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff;
   logic              take;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_period_us <= sfss_pkg::PeriodReset;
         cfg_ff.pulse_on_us    <= sfss_pkg::PulseReset;
      end else if (csr_we) begin
         unique case (csr_index)
            sfss_pkg::REG_STEP_PERIOD: cfg_ff.step_period_us <= csr_wdata;
            sfss_pkg::REG_PULSE_ON:    cfg_ff.pulse_on_us    <= csr_wdata;
            default: ;
         endcase
      end
   end

   sfss_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .take   (take),
      .item   (req_data),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SFSS_ASSERT_NEXT(a_beat_lands, clock, reset, take, rsp_valid)
   `SFSS_ASSERT_NOW(a_idle_released, clock, reset,
      rsp_valid && !rsp_data.busy_res, rsp_data.coils == 4'h0)
   `SFSS_ASSERT_NOW(a_ready_rule, clock, reset,
      !rsp_valid, req_ready)

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: full-step sequencer core testbench
// Drives move and tick beats through the req channel and rewrites the step
// timing registers between phases. A tracker class mirrors the coil and
// busy state beat by beat and checks each rsp beat in order.
// ---------------------------------------------------------------------------
import sfss_pkg::*;

class coil_sequence_tracker;
   logic [TimeW-1:0]  period;
   logic [TimeW-1:0]  pulse;
   logic [StepsW-1:0] steps_pending;
   logic [1:0]        phase;
   bit                fwd;
   logic [TimeW-1:0]  elapsed;
   logic [1:0]        stage;
   logic [3:0]        drive;
   rsp_type           expected_drive[$];
   int                errors;
   int                checked;
   int                moves_started;
   int                steps_taken;
   int                busy_ticks;

   function new();
      period = PeriodReset;
      pulse = PulseReset;
      steps_pending = '0;
      phase = '0;
      fwd = 1'b1;
      elapsed = '0;
      stage = STAGE_IDLE;
      drive = 4'h0;
      errors = 0;
      checked = 0;
      moves_started = 0;
      steps_taken = 0;
      busy_ticks = 0;
   endfunction

   function bit busy();
      return stage == STAGE_ON || stage == STAGE_OFF;
   endfunction

   function int outstanding();
      return expected_drive.size();
   endfunction

   function void set_register(logic [CsrIdxW-1:0] idx, logic [TimeW-1:0] val);
      if (idx == REG_STEP_PERIOD) begin
         period = val;
      end else if (idx == REG_PULSE_ON) begin
         pulse = val;
      end
   endfunction

   function logic [TimeW-1:0] off_len();
      if (pulse == 0 || pulse >= period) begin
         return '0;
      end
      return period - pulse;
   endfunction

   function void advance_step();
      elapsed = '0;
      if (steps_pending == 0) begin
         drive = 4'h0;
         stage = STAGE_IDLE;
         return;
      end
      steps_pending = steps_pending - 1'b1;
      phase = fwd ? phase + 2'd1 : phase - 2'd1;
      case (phase)
         2'd0:    drive = 4'hA;
         2'd1:    drive = 4'h6;
         2'd2:    drive = 4'h5;
         default: drive = 4'h9;
      endcase
      stage = STAGE_ON;
      steps_taken++;
   endfunction

   function void note_beat(req_type b);
      logic [15:0]      raw;
      logic [15:0]      mag;
      logic [TimeW-1:0] on_len;
      rsp_type          exp_beat;
      raw = b.step_count;
      on_len = (pulse != 0) ? pulse : period;
      if (b.op == OP_MOVE) begin
         if (!busy() && raw != 0) begin
            if (raw[15]) begin
               mag = -raw;
               if (mag > 16'h7FFF) mag = 16'h7FFF;
               fwd = 1'b0;
               phase = mag[1:0];
            end else begin
               mag = raw;
               fwd = 1'b1;
               phase = 2'd0;
            end
            steps_pending = mag[StepsW-1:0];
            moves_started++;
            advance_step();
         end
      end else if (stage == STAGE_ON) begin
         busy_ticks++;
         elapsed = elapsed + 1'b1;
         if (elapsed >= on_len) begin
            if (off_len() != 0) begin
               drive = 4'h0;
               stage = STAGE_OFF;
               elapsed = '0;
            end else begin
               advance_step();
            end
         end
      end else if (stage == STAGE_OFF) begin
         busy_ticks++;
         elapsed = elapsed + 1'b1;
         if (elapsed >= off_len()) advance_step();
      end else begin
         stage = STAGE_IDLE;
         drive = 4'h0;
      end
      exp_beat.coils = drive;
      exp_beat.busy_res = busy();
      expected_drive.push_back(exp_beat);
   endfunction

   function void check_drive(rsp_type got);
      rsp_type exp_beat;
      if (expected_drive.size() == 0) begin
         $error("rsp beat with nothing pending: coils %h busy_res %b",
                got.coils, got.busy_res);
         errors++;
         return;
      end
      exp_beat = expected_drive.pop_front();
      checked++;
      if (got.coils !== exp_beat.coils) begin
         $error("coils: expected %h, actual %h", exp_beat.coils, got.coils);
         errors++;
      end
      if (got.busy_res !== exp_beat.busy_res) begin
         $error("busy_res: expected %b, actual %b", exp_beat.busy_res, got.busy_res);
         errors++;
      end
   endfunction
endclass

module tb_top;
   localparam logic [CsrIdxW-1:0] REG_SPARE_2 = 2'd2;
   localparam logic [CsrIdxW-1:0] REG_SPARE_3 = 2'd3;
   localparam int RandomBeats = 420;

   typedef enum logic [1:0] {SINK_OPEN, SINK_ALTERNATE, SINK_RANDOM, SINK_SLOW} sink_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we = 1'b0;
   logic [CsrIdxW-1:0]  csr_index = '0;
   logic [TimeW-1:0]    csr_wdata = '0;

   coil_sequence_tracker sb;
   int                   burst_left = 0;
   sink_mode_type        sink_mode = SINK_OPEN;
   int                   sink_left = 0;

   stepper_full_step_sequencer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (sink_left == 0) begin
         sink_mode <= sink_mode_type'($urandom_range(0, 3));
         sink_left <= $urandom_range(20, 200);
      end else begin
         sink_left <= sink_left - 1;
      end
      case (sink_mode)
         SINK_OPEN:      rsp_ready <= 1'b1;
         SINK_ALTERNATE: rsp_ready <= ~rsp_ready;
         SINK_RANDOM:    rsp_ready <= ($urandom_range(0, 3) != 0);
         default:        rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_drive(rsp_data);
   end

   task automatic push(input logic op_bit, input logic [15:0] count);
      req_type beat;
      int      gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      beat.op = op_bit;
      beat.step_count = count;
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (!req_ready);
      sb.note_beat(beat);
      burst_left--;
   endtask

   task automatic ticks(input int n);
      repeat (n) push(OP_TICK, 16'($urandom));
   endtask

   task automatic run_out();
      while (sb.busy()) push(OP_TICK, 16'($urandom));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxW-1:0] idx, input logic [TimeW-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_register(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic new_random_setting();
      logic [TimeW-1:0] per;
      logic [TimeW-1:0] pul;
      per = 24'($urandom_range(0, 8));
      case ($urandom_range(0, 4))
         0:       begin per = '0; pul = '0; end
         1:       pul = '0;
         2:       pul = (per > 1) ? 24'($urandom_range(1, int'(per) - 1)) : 24'd1;
         3:       pul = 24'($urandom_range(int'(per), int'(per) + 4));
         default: begin per = '0; pul = 24'($urandom_range(1, 5)); end
      endcase
      wait_drain();
      if ($urandom_range(0, 3) == 0) begin
         write_reg(REG_PULSE_ON, pul);
      end else begin
         write_reg(REG_STEP_PERIOD, per);
         write_reg(REG_PULSE_ON, pul);
      end
   endtask

   function automatic logic [15:0] short_move();
      logic [15:0] mag;
      mag = 16'($urandom_range(1, 6));
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   initial begin
      int useful;
      int pick;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset timing, then shorten the period mid-step
      push(OP_MOVE, 16'd1);
      ticks(3);
      wait_drain();
      write_reg(REG_STEP_PERIOD, 24'd2);
      ticks(2);
      // pulsed steps with an off stage
      wait_drain();
      write_reg(REG_STEP_PERIOD, 24'd3);
      write_reg(REG_PULSE_ON, 24'd1);
      push(OP_MOVE, 16'd2);
      run_out();
      push(OP_MOVE, 16'd0);
      push(OP_TICK, 16'hFFFF);
      // backward move, moves while busy are dropped
      push(OP_MOVE, -16'sd5);
      push(OP_TICK, 16'h0000);
      push(OP_MOVE, 16'h7FFF);
      push(OP_MOVE, 16'h8000);
      run_out();
      // pulse not shorter than the period: no off stage
      wait_drain();
      write_reg(REG_PULSE_ON, 24'd5);
      push(OP_MOVE, -16'sd1);
      run_out();
      wait_drain();
      write_reg(REG_PULSE_ON, 24'd3);
      push(OP_MOVE, 16'd3);
      run_out();
      // zero period: zero-length steps, then a pulse with no off stage
      wait_drain();
      write_reg(REG_PULSE_ON, 24'd0);
      write_reg(REG_STEP_PERIOD, 24'd0);
      push(OP_MOVE, 16'd2);
      run_out();
      wait_drain();
      write_reg(REG_PULSE_ON, 24'd2);
      push(OP_MOVE, -16'sd2);
      run_out();
      // register extremes, released mid-step
      wait_drain();
      write_reg(REG_STEP_PERIOD, 24'hFFFFFF);
      write_reg(REG_PULSE_ON, 24'hFFFFFF);
      push(OP_MOVE, 16'd1);
      ticks(2);
      wait_drain();
      write_reg(REG_PULSE_ON, 24'd0);
      ticks(1);
      wait_drain();
      write_reg(REG_STEP_PERIOD, 24'd1);
      ticks(1);
      // spare indexes are ignored
      wait_drain();
      write_reg(REG_SPARE_2, 24'h123456);
      write_reg(REG_SPARE_3, 24'hFFFFFF);
      push(OP_MOVE, 16'd2);
      run_out();

      useful = 0;
      new_random_setting();
      while (useful < RandomBeats) begin
         if ($urandom_range(0, 79) == 0) new_random_setting();
         if (!sb.busy()) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               push(OP_MOVE, 16'd0);
            end else if (pick == 1) begin
               push(OP_TICK, 16'($urandom));
            end else begin
               push(OP_MOVE, short_move());
               useful++;
            end
         end else if ($urandom_range(0, 11) == 0) begin
            push(OP_MOVE, 16'($urandom));
         end else begin
            push(OP_TICK, 16'($urandom));
            useful++;
         end
         if ($urandom_range(0, 149) == 0) wait_drain();
      end

      // most negative count saturates; first steps only
      wait_drain();
      write_reg(REG_STEP_PERIOD, 24'd0);
      write_reg(REG_PULSE_ON, 24'd0);
      push(OP_MOVE, 16'h8000);
      ticks(8);

      wait_drain();
      repeat (4) @(posedge clock);
      $display("run covered %0d moves, %0d steps and %0d active ticks",
               sb.moves_started, sb.steps_taken, sb.busy_ticks);
      $display("%0d rsp beats checked, %0d mismatches", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("stepper_full_step_sequencer_core test passed");
      end else begin
         $display("stepper_full_step_sequencer_core test failed");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d rsp beats pending", sb.outstanding());
      $display("stepper_full_step_sequencer_core test failed");
      $finish;
   end
endmodule

/* sim.f */
+incdir+sv
sv/sfss_pkg.sv
sv/sfss_engine.sv
sv/stepper_full_step_sequencer_core.sv
test/tb_top.sv
